FILE: rtl/sbr_pkg.sv
// Shared types and constants for the stream byte reassembler.
`timescale 1ns / 1ps
package sbr_pkg;

  localparam int CAP_DEFAULT = 4096;

  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_END  = 2'd1;
  localparam logic [1:0] CMD_PULL = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] stream_index;
    logic [7:0]  data_byte;
    logic        last_of_final;
    logic [12:0] free_space;
  } req_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        stream_closed;
    logic [12:0] pending_count;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic read;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: rtl/sbr_ctrl.sv
// Sequencer for the stream byte reassembler: clear pass, accept, read, execute.
`timescale 1ns / 1ps
module sbr_ctrl
  import sbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd,
  output logic      req_stall
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign req_stall = (state != S_IDLE);

endmodule

FILE: rtl/sbr_datapath.sv
// Datapath for the stream byte reassembler: ring store, window check, counters.
`timescale 1ns / 1ps
module sbr_datapath
  import sbr_pkg::*;
#(
  parameter int CAP = CAP_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  input  req_t      req_data,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_t      rsp_data
);

  localparam int AW = $clog2(CAP);
  localparam int RW = $clog2(CAP + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAP - 1);
  localparam logic [AW:0]   CAP_W     = (AW + 1)'(CAP);
  localparam logic [16:0]   CAP_17    = 17'(CAP);

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } entry_t;

  entry_t mem [CAP];
  entry_t rd_q;

  logic [1:0]    cmd_q;
  logic [63:0]   idx_q;
  logic [7:0]    byte_q;
  logic [RW-1:0] room_q;

  logic [63:0]   next_expected;
  logic [AW-1:0] ne_slot;
  logic          end_known;
  logic [63:0]   end_position;
  logic [RW-1:0] held_count;
  logic          closed_flag;
  logic [AW-1:0] clr_addr;

  logic          win_q;
  logic [AW-1:0] wr_slot_q;
  logic          ge_cur_q;
  logic          ge_inc_q;

  logic          out_full;

  // item capture
  logic [16:0] fs_ext;
  logic [16:0] room_sat;
  assign fs_ext   = 17'(req_data.free_space);
  assign room_sat = (fs_ext > CAP_17) ? CAP_17 : fs_ext;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= req_data.cmd;
      idx_q  <= req_data.stream_index;
      byte_q <= req_data.data_byte;
      room_q <= RW'(room_sat);
    end
  end

  // window check and slot address
  logic [63:0]   diff;
  logic          in_win;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] data_slot;
  logic [AW-1:0] rd_addr;
  logic [63:0]   ne_plus;

  assign diff      = idx_q - next_expected;
  assign in_win    = (idx_q >= next_expected) && (diff < 64'(room_q));
  assign slot_sum  = {1'b0, ne_slot} + {1'b0, diff[AW-1:0]};
  assign data_slot = (slot_sum >= CAP_W) ? AW'(slot_sum - CAP_W) : slot_sum[AW-1:0];
  assign rd_addr   = (cmd_q == CMD_PULL) ? ne_slot : data_slot;
  assign ne_plus   = next_expected + 64'd1;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      win_q     <= in_win;
      wr_slot_q <= data_slot;
      ge_cur_q  <= (next_expected >= end_position);
      ge_inc_q  <= (ne_plus >= end_position);
    end
  end

  // execute
  logic          got;
  logic          put;
  logic          closed_next;
  logic [RW-1:0] held_next;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          out_taken;

  assign got = cmd.exec && (cmd_q == CMD_PULL) && !closed_flag && rd_q.vld;
  assign put = cmd.exec && (cmd_q == CMD_DATA) && !closed_flag && win_q && !rd_q.vld;

  always_comb begin
    held_next = held_count;
    if (put) held_next = held_count + RW'(1);
    else if (got) held_next = held_count - RW'(1);
  end

  assign closed_next = closed_flag || (end_known && (got ? ge_inc_q : ge_cur_q));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_slot_q;
    wr_data = '{vld: 1'b1, data: byte_q};
    priority if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (put) begin
      wr_en = 1'b1;
    end else if (got) begin
      wr_en   = 1'b1;
      wr_addr = ne_slot;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.read) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected <= '0;
      ne_slot       <= '0;
      end_known     <= 1'b0;
      end_position  <= '0;
      held_count    <= '0;
      closed_flag   <= 1'b0;
      clr_addr      <= '0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + AW'(1);
      if (cmd.load) begin
        if (req_data.cmd == CMD_DATA && req_data.last_of_final) begin
          end_known    <= 1'b1;
          end_position <= req_data.stream_index + 64'd1;
        end else if (req_data.cmd == CMD_END) begin
          end_known    <= 1'b1;
          end_position <= req_data.stream_index;
        end
      end
      if (cmd.exec) begin
        held_count  <= held_next;
        closed_flag <= closed_next;
      end
      if (got) begin
        next_expected <= ne_plus;
        ne_slot       <= (ne_slot == LAST_SLOT) ? '0 : ne_slot + AW'(1);
      end
    end
  end

  // response register
  assign out_taken = out_full && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.exec) begin
      out_full <= 1'b1;
    end else if (out_taken) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_data.out_valid     <= got;
      rsp_data.out_byte      <= got ? rd_q.data : 8'd0;
      rsp_data.stream_closed <= closed_next;
      rsp_data.pending_count <= 13'(held_next);
    end
  end

  assign rsp_valid      = out_full;
  assign sts.clear_done = (clr_addr == LAST_SLOT);
  assign sts.out_free   = !out_full || out_taken;

`ifndef SYNTHESIS
  a_pull_advances: assert property (@(posedge clk) disable iff (rst)
    got |=> next_expected == $past(next_expected) + 64'd1)
    else $error("delivery did not advance next index");

  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    closed_flag |=> closed_flag)
    else $error("closed flag dropped");

  a_no_take_after_close: assert property (@(posedge clk) disable iff (rst)
    closed_flag |-> !got && !put)
    else $error("store touched after close");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= RW'(CAP))
    else $error("held count above capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && out_full && rsp_stall |-> 1'b0)
    else $error("response overwritten while stalled");
`endif

endmodule

FILE: rtl/stream_byte_reassembler_top.sv
// Top level of the stream byte reassembler.
// Each request is a data byte, an end mark or a pull, and gives exactly one
// response with the delivered byte (if any), the closed status and the count
// of held bytes. A request passes through accept, a registered read of the
// ring store entry, then write-back and response; a new request is taken
// while the previous response still waits downstream. After reset the store's
// valid bits are cleared by a pass over all CAP entries, one entry per cycle,
// during which requests are stalled.
`timescale 1ns / 1ps
module stream_byte_reassembler_top
  import sbr_pkg::*;
#(
  parameter int CAP = CAP_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  sbr_datapath #(
    .CAP (CAP)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
